FILE: hw/rtl/array_insert_delete_engine_defines.svh
// ----------------------------------------------------------------------------
// Array insert/delete engine: assertion macros
// Shared macros for the concurrent checks in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef ARRAY_INSERT_DELETE_ENGINE_DEFINES_SVH
`define ARRAY_INSERT_DELETE_ENGINE_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define AIDE_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("aide invariant violated");

// Check a consequence in the cycle after a condition, outside reset.
`define AIDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aide next-cycle check violated");

`endif

FILE: hw/rtl/aide_pkg.sv
// ----------------------------------------------------------------------------
// aide_pkg
// Types, opcodes and status codes shared by the array insert/delete engine.
// ----------------------------------------------------------------------------
package aide_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int STAT_W    = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_SORT = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_ALL  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } aide_req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        element_count;
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        removed_count;
    } aide_rsp_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic shift_up;    // open a gap at the index and load the value
        logic shift_down;  // close the entry at the index
        logic start;       // place the scan token on the first cell
        logic adv;         // move the scan token one cell on
        logic sorted;      // scan for not-less-than instead of equal
    } aide_cell_ctl_t;

endpackage

FILE: hw/rtl/array_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// array_insert_delete_engine
// Packed array of signed words with insert, sorted insert, delete, delete by
// value, delete all and read, built as a chain of storage cells.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken, worked on and its single result
// is placed in an output register, after which the next request is taken
// even if that result is still waiting. Insert at, delete at, read, unused
// opcodes and requests refused as full or for a bad position go from the
// start state straight to the result state. Sorted insert, delete value and
// delete all walk a token down the cell chain, one cell per cycle; a removal
// keeps the token in place for the entry that slides in, and the walk ends
// at the end of the stored entries (sorted insert and delete value stop at
// the first hit). A finished request waits while an earlier result is still
// stalled. Each shift moves all affected stored entries in the same cycle.
// ----------------------------------------------------------------------------
`include "array_insert_delete_engine_defines.svh"

module array_insert_delete_engine #(
    parameter int DEPTH = aide_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  aide_pkg::aide_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output aide_pkg::aide_rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > aide_pkg::POS_W) ? CW : aide_pkg::POS_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic [CW-1:0]                       k_reg;
    logic [CW-1:0]                       k_next;
    logic                                rsp_valid_reg;
    logic                                rsp_valid_next;

    aide_pkg::aide_req_t                 req_reg;
    aide_pkg::aide_rsp_t                 rsp_reg;
    aide_pkg::aide_rsp_t                 rsp_next;
    logic [CW-1:0]                       rem_reg;
    logic [CW-1:0]                       rem_next;
    logic signed [aide_pkg::VAL_W-1:0]   rd_reg;
    logic signed [aide_pkg::VAL_W-1:0]   rd_next;
    logic [aide_pkg::STAT_W-1:0]         stat_reg;
    logic [aide_pkg::STAT_W-1:0]         stat_next;

    aide_pkg::aide_cell_ctl_t            ctl;
    logic [AW-1:0]                       cell_idx;
    logic signed [aide_pkg::VAL_W-1:0]   ent [DEPTH];
    logic [DEPTH-1:0]                    tok_vec;
    logic [DEPTH-1:0]                    cond_vec;

    logic [PW-1:0]                       pos_ext;
    logic [PW-1:0]                       cnt_ext;
    logic [PW-1:0]                       pos_m1;
    logic [AW-1:0]                       rd_idx;
    logic signed [aide_pkg::VAL_W-1:0]   rd_sel;
    logic                                full;
    logic                                pos_bad;
    logic                                scan_end;
    logic                                hit;
    logic                                rsp_free;

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [aide_pkg::VAL_W-1:0] left_data;
            logic signed [aide_pkg::VAL_W-1:0] right_data;
            logic                              left_tok;

            if (gi == 0)
            begin : g_head
                assign left_data = '0;
                assign left_tok  = 1'b0;
            end
            else
            begin : g_body
                assign left_data = ent[gi-1];
                assign left_tok  = tok_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_data = '0;
            end
            else
            begin : g_next
                assign right_data = ent[gi+1];
            end

            aide_cell #(
                .AW  (AW),
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .idx        (cell_idx),
                .val        (req_reg.item_value),
                .left_data  (left_data),
                .right_data (right_data),
                .left_tok   (left_tok),
                .entry      (ent[gi]),
                .tok        (tok_vec[gi]),
                .cond       (cond_vec[gi])
            );
        end
    endgenerate

    // Decode position and count checks
    assign pos_ext  = PW'(req_reg.position);
    assign cnt_ext  = PW'(count_reg);
    assign pos_m1   = pos_ext - PW'(1);
    assign rd_idx   = AW'(pos_m1);
    assign full     = (count_reg == CW'(DEPTH));
    assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
    assign scan_end = (k_reg >= count_reg);
    assign hit      = |cond_vec;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Select the addressed entry for a read
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (AW'(i) == rd_idx)
                rd_sel = rd_sel | ent[i];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        rem_next       = rem_reg;
        rd_next        = rd_reg;
        stat_next      = stat_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ctl            = '0;
        ctl.sorted     = (req_reg.opcode == aide_pkg::OP_INS_SORT);
        cell_idx       = '0;

        // drop the result once it has been taken
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_START;
            end

            ST_START:
            begin
                rd_next    = '0;
                stat_next  = aide_pkg::STAT_OK;
                rem_next   = '0;
                k_next     = '0;
                state_next = ST_RESP;
                unique case (req_reg.opcode) inside
                    aide_pkg::OP_INS_AT:
                    begin
                        if (full)
                            stat_next = aide_pkg::STAT_FULL;
                        else if (pos_ext == '0)
                            stat_next = aide_pkg::STAT_BADPOS;
                        else
                        begin
                            ctl.shift_up = 1'b1;
                            cell_idx     = (pos_m1 >= cnt_ext) ? AW'(count_reg)
                                                               : AW'(pos_m1);
                            count_next   = count_reg + CW'(1);
                        end
                    end

                    aide_pkg::OP_INS_SORT:
                    begin
                        if (full)
                            stat_next = aide_pkg::STAT_FULL;
                        else
                        begin
                            ctl.start  = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end

                    aide_pkg::OP_DEL_AT:
                    begin
                        if (pos_bad)
                            stat_next = aide_pkg::STAT_BADPOS;
                        else
                        begin
                            ctl.shift_down = 1'b1;
                            cell_idx       = rd_idx;
                            count_next     = count_reg - CW'(1);
                            rem_next       = CW'(1);
                        end
                    end

                    aide_pkg::OP_DEL_VAL, aide_pkg::OP_DEL_ALL:
                    begin
                        ctl.start  = 1'b1;
                        state_next = ST_SCAN;
                    end

                    aide_pkg::OP_READ:
                    begin
                        if (pos_bad)
                            stat_next = aide_pkg::STAT_BADPOS;
                        else
                            rd_next = rd_sel;
                    end

                    default:
                    begin
                        stat_next = aide_pkg::STAT_OK;
                    end
                endcase
            end

            ST_SCAN:
            begin
                cell_idx = AW'(k_reg);
                if (scan_end)
                begin
                    // ran past the last entry
                    state_next = ST_RESP;
                    if (req_reg.opcode == aide_pkg::OP_INS_SORT)
                    begin
                        ctl.shift_up = 1'b1;
                        count_next   = count_reg + CW'(1);
                    end
                    else if (req_reg.opcode == aide_pkg::OP_DEL_VAL)
                        stat_next = aide_pkg::STAT_NOTFOUND;
                    else if (rem_reg == '0)
                        stat_next = aide_pkg::STAT_NOTFOUND;
                end
                else if (hit)
                begin
                    if (req_reg.opcode == aide_pkg::OP_INS_SORT)
                    begin
                        ctl.shift_up = 1'b1;
                        count_next   = count_reg + CW'(1);
                        state_next   = ST_RESP;
                    end
                    else
                    begin
                        // close the matching entry; delete all keeps the token here
                        ctl.shift_down = 1'b1;
                        count_next     = count_reg - CW'(1);
                        rem_next       = rem_reg + CW'(1);
                        if (req_reg.opcode == aide_pkg::OP_DEL_VAL)
                            state_next = ST_RESP;
                    end
                end
                else
                begin
                    ctl.adv = 1'b1;
                    k_next  = k_reg + CW'(1);
                end
            end

            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next.read_value    = rd_reg;
                    rsp_next.element_count = aide_pkg::CNT_W'(count_reg);
                    rsp_next.status        = stat_reg;
                    rsp_next.removed_count = aide_pkg::CNT_W'(rem_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            req_reg <= req;
        rem_reg  <= rem_next;
        rd_reg   <= rd_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `AIDE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    `AIDE_ASSERT_ALWAYS(a_token_single, clk, rst_n, $onehot0(tok_vec))
    `AIDE_ASSERT_NEXT(a_idle_count_hold, clk, rst_n, state_reg == ST_IDLE, $stable(count_reg))
    `AIDE_ASSERT_NEXT(a_resp_loads, clk, rst_n, state_reg == ST_RESP && rsp_free, rsp_valid_reg)

endmodule

FILE: hw/rtl/aide_cell.sv
// ----------------------------------------------------------------------------
// aide_cell
// One storage cell of the chain: holds one entry and one scan-token bit,
// takes data from either neighbor on a shift and tests its own entry when
// it holds the token.
// ----------------------------------------------------------------------------
module aide_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aide_pkg::aide_cell_ctl_t         ctl,
    input  logic [AW-1:0]                    idx,
    input  logic signed [aide_pkg::VAL_W-1:0] val,
    input  logic signed [aide_pkg::VAL_W-1:0] left_data,
    input  logic signed [aide_pkg::VAL_W-1:0] right_data,
    input  logic                             left_tok,
    output logic signed [aide_pkg::VAL_W-1:0] entry,
    output logic                             tok,
    output logic                             cond
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic signed [aide_pkg::VAL_W-1:0] entry_reg;
    logic signed [aide_pkg::VAL_W-1:0] entry_next;
    logic                              tok_reg;
    logic                              tok_next;
    logic                              is_less;

    // Select the entry source for this cycle
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_up)
        begin
            if (MY_IDX > idx)
                entry_next = left_data;
            else if (MY_IDX == idx)
                entry_next = val;
        end
        else if (ctl.shift_down)
        begin
            if (MY_IDX >= idx)
                entry_next = right_data;
        end
    end

    // Move the scan token along the chain
    always_comb
    begin
        tok_next = tok_reg;
        if (ctl.start)
            tok_next = (IDX == 0);
        else if (ctl.adv)
            tok_next = left_tok;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_next;
    end

    // Local match test, only meaningful under the token
    assign is_less = entry_reg < val;
    assign cond    = tok_reg & (ctl.sorted ? ~is_less : (entry_reg == val));
    assign entry   = entry_reg;
    assign tok     = tok_reg;

endmodule

FILE: tb/aide_result_checker.sv
// ----------------------------------------------------------------------------
// aide_result_checker
// Watches both channels of the array insert/delete engine. It keeps a shadow
// copy of the packed array, works out the result of every request transfer,
// and compares each result transfer field by field with the oldest one due.
// ----------------------------------------------------------------------------
module aide_result_checker #(
    parameter int DEPTH = aide_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  aide_pkg::aide_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  aide_pkg::aide_rsp_t rsp,
    output int                  fault_count,
    output int                  waiting
);
    import aide_pkg::*;

    logic signed [VAL_W-1:0] shadow_words [DEPTH];
    int unsigned             shadow_count;
    aide_rsp_t               due_results [$];
    int                      fault_total = 0;
    int unsigned             result_index = 0;

    // Count a failure; report only the first few
    function automatic void log_fault(string note);
        fault_total++;
        if (fault_total <= 10)
            $display("%s", note);
    endfunction

    // Open a gap at idx, moving later words up, and place the value there
    function automatic void open_slot(int unsigned idx, logic signed [VAL_W-1:0] value);
        int unsigned i;
        for (i = shadow_count; i > idx; i--)
            shadow_words[i] = shadow_words[i - 1];
        shadow_words[idx] = value;
        shadow_count++;
    endfunction

    // Close the word at idx, moving later words down
    function automatic void close_slot(int unsigned idx);
        int unsigned i;
        for (i = idx; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
        shadow_count--;
    endfunction

    // Apply one request to the shadow array and return the result it gives
    function automatic aide_rsp_t predict_result(aide_req_t r);
        aide_rsp_t   res;
        int unsigned pos;
        int unsigned idx;
        int unsigned kept;
        res = '0;
        res.status = STAT_OK;
        pos = 32'(r.position);
        case (r.opcode)
            OP_INS_AT:
            begin
                if (shadow_count >= DEPTH)
                    res.status = STAT_FULL;
                else if (pos == 0)
                    res.status = STAT_BADPOS;
                else
                    open_slot((pos - 1 >= shadow_count) ? shadow_count : pos - 1,
                              r.item_value);
            end
            OP_INS_SORT:
            begin
                if (shadow_count >= DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    idx = 0;
                    while (idx < shadow_count && shadow_words[idx] < r.item_value)
                        idx++;
                    open_slot(idx, r.item_value);
                end
            end
            OP_DEL_AT:
            begin
                if (pos == 0 || pos > shadow_count)
                    res.status = STAT_BADPOS;
                else
                begin
                    close_slot(pos - 1);
                    res.removed_count = CNT_W'(1);
                end
            end
            OP_DEL_VAL:
            begin
                idx = 0;
                while (idx < shadow_count && shadow_words[idx] != r.item_value)
                    idx++;
                if (idx >= shadow_count)
                    res.status = STAT_NOTFOUND;
                else
                begin
                    close_slot(idx);
                    res.removed_count = CNT_W'(1);
                end
            end
            OP_DEL_ALL:
            begin
                // compact the survivors toward the front
                kept = 0;
                for (idx = 0; idx < shadow_count; idx++)
                begin
                    if (shadow_words[idx] != r.item_value)
                    begin
                        shadow_words[kept] = shadow_words[idx];
                        kept++;
                    end
                end
                res.removed_count = CNT_W'(shadow_count - kept);
                if (shadow_count == kept)
                    res.status = STAT_NOTFOUND;
                shadow_count = kept;
            end
            OP_READ:
            begin
                if (pos == 0 || pos > shadow_count)
                    res.status = STAT_BADPOS;
                else
                    res.read_value = shadow_words[pos - 1];
            end
            default:
            begin
                // spare opcodes leave the array alone
            end
        endcase
        res.element_count = CNT_W'(shadow_count);
        return res;
    endfunction

    // Predict on every request transfer, compare on every result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            due_results.delete();
            waiting     <= 0;
            fault_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                due_results.push_back(predict_result(req));
            if (rsp_valid && !rsp_stall)
            begin : compare
                aide_rsp_t want;
                if (due_results.size() == 0)
                    log_fault($sformatf({"result %0d with nothing due: value %0d",
                                         " count %0d status %0d removed %0d"},
                                        result_index, rsp.read_value,
                                        rsp.element_count, rsp.status,
                                        rsp.removed_count));
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.read_value !== want.read_value
                        || rsp.element_count !== want.element_count
                        || rsp.status !== want.status
                        || rsp.removed_count !== want.removed_count)
                        log_fault($sformatf({"result %0d mismatch: expected value %0d",
                                             " count %0d status %0d removed %0d,",
                                             " got value %0d count %0d status %0d",
                                             " removed %0d"},
                                            result_index, want.read_value,
                                            want.element_count, want.status,
                                            want.removed_count, rsp.read_value,
                                            rsp.element_count, rsp.status,
                                            rsp.removed_count));
                end
                result_index++;
            end
            waiting     <= due_results.size();
            fault_count <= fault_total;
        end
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the array insert/delete engine with a directed opening and then
// rotating fill, mixed and drain phases of random requests, with random gaps
// on the request side and random stalls on the result side. Checking is done
// by the result checker placed beside the engine.
// ----------------------------------------------------------------------------
module testbench;
    import aide_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 830;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    // Opcodes the engine leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int unsigned {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    aide_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    aide_rsp_t rsp;
    int        fault_count;
    int        waiting;

    bit          calm        = 1'b0;
    int unsigned rsp_hold    = 0;
    int          idle_cycles = 0;

    array_insert_delete_engine #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    aide_result_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fault_count (fault_count),
        .waiting     (waiting)
    );

    always #1 clk = ~clk;

    // Idle cycles for the next item; none during a calm stretch
    function automatic int unsigned pick_wait();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Send one request after a random gap and hold it until its transfer
    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] value);
        aide_req_t   item;
        int unsigned gap;
        item.opcode     = op;
        item.position   = pos;
        item.item_value = value;
        gap = pick_wait();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
    endtask

    // Stall each result for a freshly drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin : next_hold
            int unsigned hold_draw;
            hold_draw = pick_wait();
            rsp_hold  <= hold_draw;
            rsp_stall <= (hold_draw != 0);
        end
        else if (rsp_valid && rsp_hold != 0)
        begin
            rsp_hold  <= rsp_hold - 1;
            rsp_stall <= (rsp_hold > 1);
        end
    end

    // End the run when nothing has been transferred for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        phase_t                  phase;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        int unsigned             sent;
        int unsigned             seg_index;
        int unsigned             seg_len;
        int unsigned             n;
        int unsigned             roll;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty array: every lookup and removal fails
        send_request(OP_READ, 7'd1, 0);
        send_request(OP_DEL_AT, 7'd1, 0);
        send_request(OP_DEL_VAL, 7'd0, 0);
        send_request(OP_DEL_ALL, 7'd0, 0);
        send_request(OP_INS_AT, 7'd0, 1);
        // Extremes, append past the end, sorted inserts with duplicates
        send_request(OP_INS_AT, 7'd1, VAL_MAX);
        send_request(OP_INS_AT, 7'd127, VAL_MIN);
        send_request(OP_INS_SORT, 7'd0, 0);
        send_request(OP_INS_SORT, 7'd64, -1);
        send_request(OP_INS_SORT, 7'd3, VAL_MIN);
        send_request(OP_INS_AT, 7'd2, 5);
        send_request(OP_READ, 7'd0, 0);
        send_request(OP_READ, 7'd1, 0);
        send_request(OP_READ, 7'd127, 0);
        send_request(OP_DEL_VAL, 7'd1, VAL_MIN);
        send_request(OP_INS_SORT, 7'd1, 5);
        send_request(OP_DEL_ALL, 7'd1, 5);
        send_request(OP_DEL_ALL, 7'd1, 77);
        send_request(OP_SPARE_LO, 7'd1, VAL_MAX);
        send_request(OP_SPARE_HI, 7'd127, VAL_MIN);
        send_request(OP_DEL_AT, 7'd127, 0);
        send_request(OP_DEL_AT, 7'd0, 0);
        send_request(OP_DEL_AT, 7'd1, 0);
        send_request(OP_READ, 7'd2, 0);

        // Rotate fill, mixed, drain and mixed phases with random content
        sent      = 0;
        seg_index = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (seg_index % 4)
                0: phase = PHASE_FILL;
                2: phase = PHASE_DRAIN;
                default: phase = PHASE_MIX;
            endcase
            case (phase)
                PHASE_FILL:  seg_len = $urandom_range(80, 110);
                PHASE_DRAIN: seg_len = $urandom_range(50, 90);
                default:     seg_len = $urandom_range(30, 60);
            endcase
            calm <= ($urandom_range(0, 4) == 0);
            for (n = 0; n < seg_len && sent < RANDOM_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                case (phase)
                    PHASE_FILL:
                        op = (roll < 45) ? OP_INS_AT :
                             (roll < 88) ? OP_INS_SORT :
                             (roll < 94) ? OP_READ : OP_DEL_VAL;
                    PHASE_DRAIN:
                        op = (roll < 35) ? OP_DEL_AT :
                             (roll < 60) ? OP_DEL_VAL :
                             (roll < 75) ? OP_DEL_ALL :
                             (roll < 90) ? OP_READ : OP_INS_SORT;
                    default:
                        op = (roll < 16) ? OP_INS_AT :
                             (roll < 32) ? OP_INS_SORT :
                             (roll < 48) ? OP_DEL_AT :
                             (roll < 62) ? OP_DEL_VAL :
                             (roll < 70) ? OP_DEL_ALL :
                             (roll < 94) ? OP_READ :
                             (roll < 97) ? OP_SPARE_LO : OP_SPARE_HI;
                endcase

                // Mostly positions in range, some zero, some anywhere
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    pos = POS_W'($urandom_range(1, DEPTH + 2));
                else if (roll == 7)
                    pos = '0;
                else
                    pos = POS_W'($urandom_range(0, 127));

                // Small values repeat often so deletes by value find matches
                roll = $urandom_range(0, 9);
                if (roll < 6)
                    value = $signed(VAL_W'($urandom_range(0, 6))) - 32'sd3;
                else if (roll < 8)
                begin
                    case ($urandom_range(0, 3))
                        0: value = VAL_MAX;
                        1: value = VAL_MIN;
                        2: value = 0;
                        default: value = -1;
                    endcase
                end
                else
                    value = $signed(VAL_W'($urandom));

                send_request(op, pos, value);
                sent++;
            end
            seg_index++;
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then let the engine settle
        do @(posedge clk); while (waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/aide_pkg.sv
hw/rtl/aide_cell.sv
hw/rtl/array_insert_delete_engine.sv
tb/aide_result_checker.sv
tb/testbench.sv
